[hdl/rita_pkg.sv]
`default_nettype none
package rita_pkg;

	// Conversion word width and derived sizes
	localparam int unsigned VALUE_BITS = 32;
	localparam int unsigned STEP_W     = $clog2(VALUE_BITS);
	localparam int unsigned CNT_W      = $clog2(VALUE_BITS) + 1;
	localparam int unsigned IDX_W      = CNT_W - 1;

	// Radix register
	localparam int unsigned RADIX_W     = 6;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	// Character set
	localparam int unsigned CHAR_W = 7;
	localparam logic [RADIX_W-1:0] DECIMAL_SPAN = 6'd10;
	localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 7'd48;
	localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 7'd97;

	// One queued transaction: the value and its zero classification
	typedef struct packed {
		logic [VALUE_BITS-1:0] number;
		logic                  is_zero;
	} entry_t;

	// Queue to back end handshake
	typedef struct packed {
		logic   valid;
		entry_t entry;
	} queue_head_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] d7;
		begin
			d7 = {1'b0, d};
			if (d < DECIMAL_SPAN)
				digit_to_ascii = d7 + CHAR_ZERO;
			else
				digit_to_ascii = d7 - {1'b0, DECIMAL_SPAN} + CHAR_LOWER_A;
		end
	endfunction

endpackage
`default_nettype wire

[hdl/rita_front.sv]
`default_nettype none
module rita_front (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic [rita_pkg::VALUE_BITS-1:0]    number,
	output rita_pkg::queue_head_t                   head,
	input  wire logic                               pop
);

	// Two-entry queue of classified values
	rita_pkg::entry_t slot_q [2];
	logic             rd_q;
	logic             wr_q;
	logic [1:0]       fill_q;
	logic             push;
	logic             do_pop;

	assign in_stall = (fill_q == 2'd2);
	assign push     = in_valid && !in_stall;
	assign do_pop   = pop && (fill_q != 2'd0);

	assign head = {(fill_q != 2'd0), slot_q[rd_q]};

	// Storage; payload needs no reset
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q].number  <= number;
			slot_q[wr_q].is_zero <= (number == '0);
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q   <= 1'b0;
			wr_q   <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push)
				wr_q <= !wr_q;
			if (do_pop)
				rd_q <= !rd_q;
			case ({push, do_pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/rita_back.sv]
`default_nettype none
module rita_back (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic [rita_pkg::RADIX_W-1:0]     base,
	input  wire rita_pkg::queue_head_t            head,
	output logic                                  pop,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic [rita_pkg::CHAR_W-1:0]           character,
	output logic                                  final_digit
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_EMIT = 2'd2;

	logic [1:0]                         state_q;
	logic [rita_pkg::VALUE_BITS-1:0]    quot_q;
	logic [rita_pkg::RADIX_W-1:0]       rem_q;
	logic [rita_pkg::STEP_W-1:0]        step_q;
	logic [rita_pkg::CNT_W-1:0]         cnt_q;
	logic [rita_pkg::IDX_W-1:0]         idx_q;
	logic [rita_pkg::RADIX_W-1:0]       store_q [rita_pkg::VALUE_BITS];
	logic                               out_valid_q;
	logic [rita_pkg::CHAR_W-1:0]        char_q;
	logic                               final_q;

	logic [rita_pkg::RADIX_W:0]         rem_sh;
	logic                               ge;
	logic [rita_pkg::RADIX_W-1:0]       rem_nx;
	logic [rita_pkg::VALUE_BITS-1:0]    quot_nx;
	logic                               last_step;
	logic                               out_free;

	// One restoring division step per cycle
	assign rem_sh    = {rem_q, quot_q[rita_pkg::VALUE_BITS-1]};
	assign ge        = (rem_sh >= {1'b0, base});
	assign rem_nx    = ge ? rita_pkg::RADIX_W'(rem_sh - {1'b0, base})
	                      : rem_sh[rita_pkg::RADIX_W-1:0];
	assign quot_nx   = {quot_q[rita_pkg::VALUE_BITS-2:0], ge};
	assign last_step = (step_q == rita_pkg::STEP_W'(rita_pkg::VALUE_BITS - 1));

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = (state_q == ST_IDLE) && head.valid;

	assign out_valid   = out_valid_q;
	assign character   = char_q;
	assign final_digit = final_q;

	// Digit store; written at the end of each division pass, and slot 0 cleared when a zero value is taken
	always_ff @(posedge clk) begin
		if (state_q == ST_DIV && last_step)
			store_q[cnt_q[rita_pkg::IDX_W-1:0]] <= rem_nx;
		else if (pop && head.entry.is_zero)
			store_q[0] <= '0;
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			char_q  <= rita_pkg::digit_to_ascii(store_q[idx_q]);
			final_q <= (idx_q == '0);
		end
	end

	// Sequencer: take value, divide digit by digit (skipped for a zero value), then emit reversed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			quot_q      <= '0;
			rem_q       <= '0;
			step_q      <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && state_q != ST_EMIT)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (head.valid) begin
						quot_q <= head.entry.number;
						rem_q  <= '0;
						step_q <= '0;
						if (head.entry.is_zero) begin
							cnt_q   <= rita_pkg::CNT_W'(1);
							idx_q   <= '0;
							state_q <= ST_EMIT;
						end else begin
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					quot_q <= quot_nx;
					if (last_step) begin
						step_q <= '0;
						rem_q  <= '0;
						cnt_q  <= cnt_q + rita_pkg::CNT_W'(1);
						if (quot_nx == '0) begin
							idx_q   <= cnt_q[rita_pkg::IDX_W-1:0];
							state_q <= ST_EMIT;
						end
					end else begin
						step_q <= step_q + rita_pkg::STEP_W'(1);
						rem_q  <= rem_nx;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						if (idx_q == '0)
							state_q <= ST_IDLE;
						else
							idx_q <= idx_q - rita_pkg::IDX_W'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
`default_nettype wire

[hdl/radix_integer_to_ascii.sv]
// Integer to ASCII conversion in a programmable base.
// Input channel: number with in_valid/in_stall; a transaction is taken when
// in_valid is high and in_stall is low. A two-entry queue holds values
// waiting for the converter, so in_stall rises only when both are full.
// Output channel: character/final_digit with out_valid/out_stall; one
// transaction per digit, most significant first, final_digit set on the last.
// Configuration: cfg_we/cfg_wdata write the radix, saturated to 2..36;
// write it only while the block is idle.
// Division: each digit is one full pass of the one-bit-per-cycle restoring
// divider over the 32-bit quotient; once division is done the digits are
// emitted, one per output transaction (at most 32, for 32 binary digits).
// A zero value skips division and gives one '0'.
// The next value is taken from the queue in the cycle after the last digit of
// the previous one is loaded into the output register.
// A stalled output holds its transaction; emission pauses until it is taken.
// Reset: queue emptied, converter idle, output invalid, radix set to ten.
`default_nettype none
module radix_integer_to_ascii (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rita_pkg::RADIX_W-1:0]      cfg_wdata,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [rita_pkg::VALUE_BITS-1:0]   number,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [rita_pkg::CHAR_W-1:0]            character,
	output logic                                   final_digit
);

	logic [rita_pkg::RADIX_W-1:0] radix_q;
	rita_pkg::queue_head_t        head;
	logic                         pop;

	// Radix register with saturation on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rita_pkg::RADIX_RESET;
		end else if (cfg_we) begin
			if (cfg_wdata < rita_pkg::RADIX_MIN)
				radix_q <= rita_pkg::RADIX_MIN;
			else if (cfg_wdata > rita_pkg::RADIX_MAX)
				radix_q <= rita_pkg::RADIX_MAX;
			else
				radix_q <= cfg_wdata;
		end
	end

	rita_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.number   (number),
		.head     (head),
		.pop      (pop)
	);

	rita_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.base        (radix_q),
		.head        (head),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.character   (character),
		.final_digit (final_digit)
	);

endmodule
`default_nettype wire

[sim/radix_integer_to_ascii_test.sv]
module radix_integer_to_ascii_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 48;
	localparam int HOLD_CYCLES  = 600;
	localparam int IDLE_SETTLE  = 8;
	localparam int END_SETTLE   = 1200;
	localparam int SILENCE_MAX  = 20000;
	localparam int REPORT_LIMIT = 10;

	typedef enum logic {ROW_NUMBER, ROW_RADIX} row_kind_t;

	typedef struct {
		row_kind_t                        kind;
		logic [rita_pkg::VALUE_BITS-1:0]  value;
		string                            text;
	} plan_row_t;

	typedef struct packed {
		logic [rita_pkg::CHAR_W-1:0] character;
		logic                        final_digit;
	} glyph_t;

	logic                            clk         = 1'b0;
	logic                            arst_n      = 1'b0;
	logic                            cfg_we      = 1'b0;
	logic [rita_pkg::RADIX_W-1:0]    cfg_wdata   = '0;
	logic                            in_valid    = 1'b0;
	logic                            in_stall;
	logic [rita_pkg::VALUE_BITS-1:0] number      = '0;
	logic                            out_valid;
	logic                            out_stall   = 1'b0;
	logic [rita_pkg::CHAR_W-1:0]     character;
	logic                            final_digit;

	// Directed rows: empty text means the predictor supplies the digits
	plan_row_t plan [0:23] = '{
		'{ROW_NUMBER, 32'd0,          "0"},
		'{ROW_NUMBER, 32'hFFFF_FFFF,  "4294967295"},
		'{ROW_NUMBER, 32'd1,          "1"},
		'{ROW_NUMBER, 32'd9,          "9"},
		'{ROW_NUMBER, 32'd10,         "10"},
		'{ROW_NUMBER, 32'h8000_0000,  "2147483648"},
		'{ROW_RADIX,  32'd0,          ""},
		'{ROW_NUMBER, 32'hFFFF_FFFF,  "11111111111111111111111111111111"},
		'{ROW_NUMBER, 32'd0,          "0"},
		'{ROW_NUMBER, 32'h8000_0000,  ""},
		'{ROW_NUMBER, 32'h5555_5555,  ""},
		'{ROW_RADIX,  32'd1,          ""},
		'{ROW_NUMBER, 32'd5,          "101"},
		'{ROW_RADIX,  32'd63,         ""},
		'{ROW_NUMBER, 32'hFFFF_FFFF,  "1z141z3"},
		'{ROW_NUMBER, 32'd35,         "z"},
		'{ROW_NUMBER, 32'd36,         "10"},
		'{ROW_RADIX,  32'd37,         ""},
		'{ROW_NUMBER, 32'd1295,       "zz"},
		'{ROW_RADIX,  32'd16,         ""},
		'{ROW_NUMBER, 32'hFFFF_FFFF,  "ffffffff"},
		'{ROW_NUMBER, 32'hA5A5_5A5A,  ""},
		'{ROW_RADIX,  32'd3,          ""},
		'{ROW_NUMBER, 32'h1234_5678,  ""}
	};

	glyph_t                       awaited_glyphs [$];
	logic [rita_pkg::RADIX_W-1:0] radix_now    = rita_pkg::RADIX_RESET;
	logic                         calm         = 1'b0;
	logic                         hold_ask     = 1'b0;
	bit                           hold_done    = 1'b0;
	int                           mismatches   = 0;
	int                           glyphs_seen  = 0;
	int                           numbers_sent = 0;
	int                           radix_writes = 0;
	int                           silent_run   = 0;
	glyph_t                       want;

	wire number_taken = in_valid && !in_stall;
	wire glyph_taken  = out_valid && !out_stall;

	radix_integer_to_ascii dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.number      (number),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.character   (character),
		.final_digit (final_digit)
	);

	always #1 clk = ~clk;

	// Digits of a value in the given base, most significant first
	function automatic void spell_number(input logic [rita_pkg::VALUE_BITS-1:0] value,
			input logic [rita_pkg::RADIX_W-1:0] base);
		logic [rita_pkg::RADIX_W-1:0]    rems [rita_pkg::VALUE_BITS];
		logic [rita_pkg::VALUE_BITS-1:0] rest;
		int                              n;
		glyph_t                          g;
		rest = value;
		n = 0;
		do begin
			rems[n] = rita_pkg::RADIX_W'(rest % base);
			n++;
			rest = rest / base;
		end while (rest != 0);
		for (int k = n - 1; k >= 0; k--) begin
			if (rems[k] < rita_pkg::DECIMAL_SPAN)
				g.character = rita_pkg::CHAR_ZERO + rems[k];
			else
				g.character = rita_pkg::CHAR_LOWER_A - rita_pkg::DECIMAL_SPAN + rems[k];
			g.final_digit = (k == 0);
			awaited_glyphs.push_back(g);
		end
	endfunction

	// Present one value and hold it until the transaction completes
	task automatic offer_number(input logic [rita_pkg::VALUE_BITS-1:0] value,
			input string text);
		glyph_t g;
		in_valid <= 1'b1;
		number   <= value;
		do @(posedge clk); while (in_stall !== 1'b0);
		numbers_sent++;
		if (text.len() != 0) begin
			for (int i = 0; i < text.len(); i++) begin
				g.character   = rita_pkg::CHAR_W'(text[i]);
				g.final_digit = (i == text.len() - 1);
				awaited_glyphs.push_back(g);
			end
		end else begin
			spell_number(value, radix_now);
		end
	endtask

	// Occasional burst of sender idling
	task automatic sender_gap();
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
	endtask

	// Stop sending and wait for every awaited character
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (awaited_glyphs.size() != 0) @(posedge clk);
		repeat (IDLE_SETTLE) @(posedge clk);
	endtask

	// Radix write; the block clamps to 2..36
	task automatic write_radix(input logic [rita_pkg::RADIX_W-1:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		radix_writes++;
		if (v < rita_pkg::RADIX_MIN)
			radix_now = rita_pkg::RADIX_MIN;
		else if (v > rita_pkg::RADIX_MAX)
			radix_now = rita_pkg::RADIX_MAX;
		else
			radix_now = v;
	endtask

	// Receiver: random stall bursts plus one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_ask && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 18)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Output checker
	always @(posedge clk) begin
		if (arst_n && glyph_taken) begin
			if (awaited_glyphs.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$display("character %0d: nothing awaited, got 0x%02h final %0b",
						glyphs_seen, character, final_digit);
			end else begin
				want = awaited_glyphs.pop_front();
				if (want !== {character, final_digit}) begin
					mismatches++;
					if (mismatches <= REPORT_LIMIT)
						$display("character %0d: expected 0x%02h final %0b, got 0x%02h final %0b",
							glyphs_seen, want.character, want.final_digit,
							character, final_digit);
				end
			end
			glyphs_seen++;
		end
	end

	// Watchdog on cycles with no transaction on either side
	initial begin
		while (silent_run < SILENCE_MAX) begin
			@(posedge clk);
			if (!arst_n || number_taken || glyph_taken)
				silent_run = 0;
			else
				silent_run++;
		end
		$display("timeout: %0d cycles without a transaction", SILENCE_MAX);
		$display("radix_integer_to_ascii_test: done, errors");
		$finish;
	end

	// Stimulus
	initial begin
		logic [rita_pkg::VALUE_BITS-1:0] v;
		longint unsigned                 p;
		logic [rita_pkg::RADIX_W-1:0]    r;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_RADIX) begin
				settle_idle();
				write_radix(plan[i].value[rita_pkg::RADIX_W-1:0]);
			end else begin
				offer_number(plan[i].value, plan[i].text);
				sender_gap();
			end
		end

		for (int phase = 0; phase < PHASES; phase++) begin
			settle_idle();
			case (phase)
				0: r = 6'd2;
				1: r = 6'd36;
				2: r = 6'd0;
				3: r = 6'd63;
				default: r = rita_pkg::RADIX_W'($urandom_range(0, 63));
			endcase
			write_radix(r);
			if (phase == 1)
				hold_ask <= 1'b1;
			if (phase == PHASES - 1)
				calm <= 1'b1;
			repeat (PHASE_ITEMS) begin
				case ($urandom_range(0, 5))
					0: v = $urandom;
					1: v = $urandom_range(0, 100);
					2: v = $urandom >> $urandom_range(0, 31);
					3: v = (32'd1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
					4: v = $urandom_range(0, 1) ? 32'hFFFF_FFFF - $urandom_range(0, 3)
						: $urandom_range(0, 3);
					default: begin
						// near a power of the base, where the digit count steps
						p = 1;
						repeat ($urandom_range(0, 31))
							if (p * radix_now <= 64'hFFFF_FFFF)
								p = p * radix_now;
						v = rita_pkg::VALUE_BITS'(p - $urandom_range(0, 1));
					end
				endcase
				offer_number(v, "");
				sender_gap();
			end
		end

		settle_idle();
		repeat (END_SETTLE) @(posedge clk);

		$display("converted %0d numbers under %0d radix writes, %0d characters checked",
			numbers_sent, radix_writes, glyphs_seen);
		$display("bases 2 and 36 plus clamped writes, one long output hold-off, %0d mismatches",
			mismatches);
		if (mismatches == 0)
			$display("radix_integer_to_ascii_test: done, clean");
		else
			$display("radix_integer_to_ascii_test: done, errors");
		$finish;
	end

endmodule
